[design/quaternion_to_euler_core_assert.svh]
// Assertion macros for the quaternion to Euler converter.
`ifndef QUATERNION_TO_EULER_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_CORE_ASSERT_SVH
// Property that must hold at every clock edge outside reset.
`define Q2E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked from reset onward as well.
`define Q2E_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/q2e_pkg.sv]
// Shared constants, types and tables for the quaternion to Euler converter.
package q2e_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CW = 40;                 // CORDIC x/y width (Q.28 with headroom)
    localparam int ZW = 36;                 // CORDIC angle width, Q.30
    localparam int SQ_STEPS = 29;           // result bits of the root of a 57-bit value
    localparam int RW = 58;                 // root remainder width
    localparam int QFIFO_DEPTH = 4;
    localparam int QFIFO_AW = 2;

    localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] ONE_Q28 = 40'sd268435456;
    localparam int OUT_SH = 30 - ANGLE_FRAC_BITS;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        cval_t sr;
        cval_t cr;
        cval_t sp;
        cval_t sy;
        cval_t cy;
        logic  clamp;
    } q2e_item_t;

    function automatic zval_t atan_entry(input int i);
        case (i)
            0: return 36'sd843314857;
            1: return 36'sd497837829;
            2: return 36'sd263043837;
            3: return 36'sd133525159;
            4: return 36'sd67021687;
            5: return 36'sd33543516;
            6: return 36'sd16775851;
            7: return 36'sd8388437;
            8: return 36'sd4194283;
            9: return 36'sd2097149;
            default: return (i >= 24) ? 36'sd64 : zval_t'(36'sd1 << (30 - i));
        endcase
    endfunction

    // Round half up from Q.30 and limit to +-lim.
    function automatic logic signed [ZW-1:0] to_out(input zval_t z, input zval_t limq);
        logic signed [ZW-1:0] r;
        logic signed [ZW-1:0] l;
        r = (z + zval_t'(36'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
        l = (limq + zval_t'(36'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
        if (r > l) return l;
        if (r < -l) return -l;
        return r;
    endfunction
endpackage

[design/q2e_front.sv]
// Front part: component products, arctangent arguments and pitch clamp test.
module q2e_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [15:0]         qw,
    input  logic signed [15:0]         qx,
    input  logic signed [15:0]         qy,
    input  logic signed [15:0]         qz,
    output logic                       item_valid,
    input  logic                       item_ready,
    output q2e_pkg::q2e_item_t         item
);
    import q2e_pkg::*;

    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [31:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    q2e_item_t   item_reg;
    q2e_item_t   item_next;
    logic        adv;

    assign adv = !s2_valid_reg || item_ready;
    assign in_ready = adv || !s1_valid_reg;
    wire take1 = in_ready;

    always_comb
    begin
        item_next.sr = cval_t'(2 * (CW'(p_wx_reg) + CW'(p_yz_reg)));
        item_next.cr = ONE_Q28 - cval_t'(2 * (CW'(p_xx_reg) + CW'(p_yy_reg)));
        item_next.sp = cval_t'(2 * (CW'(p_wy_reg) - CW'(p_zx_reg)));
        item_next.sy = cval_t'(2 * (CW'(p_wz_reg) + CW'(p_xy_reg)));
        item_next.cy = ONE_Q28 - cval_t'(2 * (CW'(p_yy_reg) + CW'(p_zz_reg)));
        item_next.clamp = (item_next.sp >= ONE_Q28) || (item_next.sp <= -ONE_Q28);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)
                s1_valid_reg <= in_valid;
            if (adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1 && in_valid)
        begin
            p_wx_reg <= qw * qx;
            p_yz_reg <= qy * qz;
            p_xx_reg <= qx * qx;
            p_yy_reg <= qy * qy;
            p_wy_reg <= qw * qy;
            p_zx_reg <= qz * qx;
            p_wz_reg <= qw * qz;
            p_xy_reg <= qx * qy;
            p_zz_reg <= qz * qz;
        end
        if (adv && s1_valid_reg)
            item_reg <= item_next;
    end

    assign item_valid = s2_valid_reg;
    assign item = item_reg;
endmodule

[design/q2e_queue.sv]
// Short queue between the front and back parts.
module q2e_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  q2e_pkg::q2e_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output q2e_pkg::q2e_item_t rd_item
);
    import q2e_pkg::*;

    q2e_item_t            mem_reg [QFIFO_DEPTH];
    logic [QFIFO_AW-1:0]  wptr_reg, rptr_reg;
    logic [QFIFO_AW:0]    cnt_reg;
    logic                 wr_en, rd_en;

    assign wr_ready = cnt_reg != QFIFO_AW'(0) + (QFIFO_AW+1)'(QFIFO_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr_en = wr_valid && wr_ready;
    assign rd_en = rd_valid && rd_ready;
    assign rd_item = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= wptr_reg + 1'b1;
            if (rd_en)
                rptr_reg <= rptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_item;
    end
endmodule

[design/q2e_back.sv]
// Back part: pipelined square root and three pipelined vectoring CORDICs.
module q2e_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  q2e_pkg::q2e_item_t item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] roll,
    output logic signed [14:0] pitch,
    output logic signed [15:0] yaw,
    output logic               clamped
);
    import q2e_pkg::*;

    localparam int NS = SQ_STEPS + 1 + CORDIC_STEPS + 2;

    typedef struct packed {
        cval_t x;
        cval_t y;
        zval_t z;
    } cstate_t;

    logic              adv;
    logic [NS-1:0]     v_reg;
    // |sp| is below 2^28 whenever the root is used
    logic [27:0]       sp_mag;
    logic [55:0]       sp_sq;
    // square-root stage data
    logic [RW-1:0]     rem_reg [SQ_STEPS+1];
    logic [RW-1:0]     root_reg [SQ_STEPS+1];
    cval_t             sp_reg [SQ_STEPS+1];
    cval_t             sr_reg [SQ_STEPS+1];
    cval_t             cr_reg [SQ_STEPS+1];
    cval_t             sy_reg [SQ_STEPS+1];
    cval_t             cy_reg [SQ_STEPS+1];
    logic              cl_reg [SQ_STEPS+1];
    // cordic stage data
    cstate_t           cs_r_reg [CORDIC_STEPS+1];
    cstate_t           cs_p_reg [CORDIC_STEPS+1];
    cstate_t           cs_y_reg [CORDIC_STEPS+1];
    logic              ccl_reg  [CORDIC_STEPS+1];
    logic signed [15:0] roll_reg, yaw_reg;
    logic signed [14:0] pitch_reg;
    logic              clamped_reg;

    assign adv = !v_reg[NS-1] || out_ready;
    assign item_ready = adv;

    always_comb
    begin
        sp_mag = 28'((item.sp < 0) ? -item.sp : item.sp);
        sp_sq = sp_mag * sp_mag;
    end

    function automatic cstate_t pre(input cval_t y, input cval_t x);
        cstate_t s;
        s.x = x;
        s.y = y;
        s.z = '0;
        if (x < 0)
        begin
            s.z = (y >= 0) ? PI_Q30 : -PI_Q30;
            s.x = -x;
            s.y = -y;
        end
        return s;
    endfunction

    function automatic cstate_t rot(input cstate_t s, input int k, input logic zero);
        cstate_t o;
        o = s;
        if (!zero)
        begin
            if (s.y >= 0)
            begin
                o.x = s.x + (s.y >>> k);
                o.y = s.y - (s.x >>> k);
                o.z = s.z + atan_entry(k);
            end
            else
            begin
                o.x = s.x - (s.y >>> k);
                o.y = s.y + (s.x >>> k);
                o.z = s.z - atan_entry(k);
            end
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-2:0], item_valid};
    end

    // Square root of 2^56 - sp^2, one result bit per stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= (58'd1 << 56) - RW'(sp_sq);
            root_reg[0] <= '0;
            sp_reg[0] <= item.sp;
            sr_reg[0] <= item.sr;
            cr_reg[0] <= item.cr;
            sy_reg[0] <= item.sy;
            cy_reg[0] <= item.cy;
            cl_reg[0] <= item.clamp;
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                logic [RW-1:0] b;
                logic [RW-1:0] t;
                b = RW'(58'd1 << (2 * (SQ_STEPS - 1 - i)));
                t = root_reg[i] + b;
                if (rem_reg[i] >= t)
                begin
                    rem_reg[i+1] <= rem_reg[i] - t;
                    root_reg[i+1] <= (root_reg[i] >> 1) + b;
                end
                else
                begin
                    rem_reg[i+1] <= rem_reg[i];
                    root_reg[i+1] <= root_reg[i] >> 1;
                end
                sp_reg[i+1] <= sp_reg[i];
                sr_reg[i+1] <= sr_reg[i];
                cr_reg[i+1] <= cr_reg[i];
                sy_reg[i+1] <= sy_reg[i];
                cy_reg[i+1] <= cy_reg[i];
                cl_reg[i+1] <= cl_reg[i];
            end
            cs_r_reg[0] <= pre(sr_reg[SQ_STEPS], cr_reg[SQ_STEPS]);
            cs_p_reg[0] <= pre(sp_reg[SQ_STEPS], cval_t'(root_reg[SQ_STEPS]));
            cs_y_reg[0] <= pre(sy_reg[SQ_STEPS], cy_reg[SQ_STEPS]);
            ccl_reg[0] <= cl_reg[SQ_STEPS];
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                // atan2(0,0) is zero: a zero pair stays zero, so freeze it
                cs_r_reg[k+1] <= rot(cs_r_reg[k], k,
                    cs_r_reg[k].x == 0 && cs_r_reg[k].y == 0);
                cs_p_reg[k+1] <= rot(cs_p_reg[k], k, 1'b0);
                cs_y_reg[k+1] <= rot(cs_y_reg[k], k,
                    cs_y_reg[k].x == 0 && cs_y_reg[k].y == 0);
                ccl_reg[k+1] <= ccl_reg[k];
            end
            roll_reg <= 16'(to_out(cs_r_reg[CORDIC_STEPS].z, PI_Q30));
            yaw_reg <= 16'(to_out(cs_y_reg[CORDIC_STEPS].z, PI_Q30));
            clamped_reg <= ccl_reg[CORDIC_STEPS];
            if (ccl_reg[CORDIC_STEPS])
                pitch_reg <= (cs_p_reg[CORDIC_STEPS].z > 0) ? 15'(to_out(HALF_PI_Q30, HALF_PI_Q30))
                                                             : 15'(-to_out(HALF_PI_Q30, HALF_PI_Q30));
            else
                pitch_reg <= 15'(to_out(cs_p_reg[CORDIC_STEPS].z, HALF_PI_Q30));
        end
    end

    assign out_valid = v_reg[NS-1];
    assign roll = roll_reg;
    assign pitch = pitch_reg;
    assign yaw = yaw_reg;
    assign clamped = clamped_reg;
endmodule

[design/quaternion_to_euler_core.sv]
// Quaternion to Euler angles (ZYX) converter. Takes one word per clock when
// the result side keeps up: a two-stage product front end feeds a four-word
// queue, and the back end is a fully pipelined 29-stage square root followed
// by three 16-stage vectoring CORDICs, sustaining one word per cycle while
// the result side keeps up. Roll and yaw are Q3.13 radians, pitch is Q2.13.
module quaternion_to_euler_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // roll_angle, pitch_angle, yaw_angle, pitch_clamped
    output logic        m_axis_tuser   // unused flag slot, zero
);
    import q2e_pkg::*;

    logic       f_valid, f_ready, q_valid, q_ready;
    q2e_item_t  f_item, q_item;
    logic signed [15:0] roll, yaw;
    logic signed [14:0] pitch;
    logic       clamped;

    q2e_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .qw(s_axis_tdata[15:0]), .qx(s_axis_tdata[31:16]),
        .qy(s_axis_tdata[47:32]), .qz(s_axis_tdata[63:48]),
        .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
    );

    q2e_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    q2e_back u_back (
        .clk(clk), .rst_n(rst_n),
        .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .roll(roll), .pitch(pitch), .yaw(yaw), .clamped(clamped)
    );

    assign m_axis_tdata = {clamped, yaw, pitch, roll};
    assign m_axis_tuser = 1'b0;
endmodule

[design/q2e_checker.sv]
// Port-level checker for the converter, bound to the top level.
`include "quaternion_to_euler_core_assert.svh"
module q2e_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    `Q2E_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word dropped while stalled")
    `Q2E_ASSERT(a_clamp_pitch, m_axis_tvalid && m_axis_tdata[47] |-> m_axis_tdata[30:16] == 15'sd12868 || m_axis_tdata[30:16] == -15'sd12868, "clamped pitch not at pi/2")
    `Q2E_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "result valid in reset")
    `Q2E_ASSERT(a_tready_free, !m_axis_tvalid |-> s_axis_tready, "input stalled with an empty output")
endmodule

bind quaternion_to_euler_core q2e_port_checker u_q2e_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
